[rtl/hfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types and constants of the tick-driven process scheduler.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int PROC_MAX_DEF  = 64;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the channels.
  localparam int OPC_W   = 2;
  localparam int IDX_W   = 6;
  localparam int TIN_W   = 16;
  localparam int TICK_W  = 24;
  localparam int WAIT_W  = 24;
  localparam int CNT_W   = 7;
  localparam int WSUM_W  = 32;
  localparam int CFG_W   = 7;

  // Operation codes.
  localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPC_W-1:0] OP_START = 2'd1;
  localparam logic [OPC_W-1:0] OP_TICK  = 2'd2;

  // Register indexes.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] entry_index;
    logic [TIN_W-1:0] arrival_time;
    logic [TIN_W-1:0] burst_length;
  } req_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_number;
    logic [IDX_W-1:0]  running_id;
    logic              cpu_busy;
    logic [CNT_W-1:0]  waiting_now;
    logic              finished_now;
    logic [CNT_W-1:0]  completed_count;
    logic              all_done;
    logic [WSUM_W-1:0] total_wait;
    logic [TICK_W-1:0] total_run;
  } rsp_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL_RD,
    S_SEL_EV,
    S_SEL_CMP,
    S_SEL_END,
    S_TK_RD,
    S_TK_EV,
    S_TK_END,
    S_OUT
  } state_t;

  // Which selection a pass over the entries serves.
  typedef enum logic [1:0] {
    PK_START,
    PK_PRE,
    PK_POST
  } pass_t;

endpackage

[rtl/hfs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface hfs_req_if import hfs_pkg::*; ();
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfs_rsp_if import hfs_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/hfs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/hrrn_fcfs_process_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_fcfs_process_scheduler
// Start: a selection pass over the active entries. Tick: a pass charging
// wait and run time, led by a selection pass if the running process is done
// or out of range, followed by one if it ends on that tick. Load: stores an
// in-range entry. One word at a time, taken only while idle; the single
// process RAM read port sets the pace. Reset (synchronous, active high)
// clears state, counters and done marks, and selects HRRN, one active entry.
// ----------------------------------------------------------------------------
module hrrn_fcfs_process_scheduler import hfs_pkg::*; #(
  parameter int MAX_PROCESSES = PROC_MAX_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  hfs_req_if.sink          req,
  hfs_rsp_if.source        rsp
);

  localparam int IW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int NW  = $clog2(MAX_PROCESSES + 1);
  localparam int CW  = (NW > CFG_W) ? NW : CFG_W;
  localparam int TB  = TIME_BITS;
  localparam int TW  = (TB > TICK_W) ? TB : TICK_W;
  localparam int EW  = TW + 2;
  localparam int RW  = 2 * TB + WAIT_W;
  localparam int PW  = WAIT_W + TB;
  localparam logic [TICK_W-1:0] MAX24 = '1;
  localparam logic [WSUM_W-1:0] MAX32 = '1;
  localparam logic [CNT_W-1:0]  MAX7  = '1;

  // Configuration and scheduler state.
  logic              policy;
  logic [CFG_W-1:0]  active_count;
  logic [MAX_PROCESSES-1:0] done;
  logic [IW-1:0]     cur;
  logic [TICK_W-1:0] tick_counter;
  logic [CNT_W-1:0]  finished;
  logic [WSUM_W-1:0] wait_sum;
  logic [TICK_W-1:0] run_sum;

  // Per-item working registers.
  state_t            state, state_next;
  pass_t             pk;
  logic [IW-1:0]     idx;
  logic [TICK_W-1:0] t_cur;
  logic              busy_f, fin_f;
  logic [NW-1:0]     waiting;
  logic [EW-1:0]     cur_end;
  logic              e_found, r_found;
  logic [IW-1:0]     e_best, r_best;
  logic [TB-1:0]     e_arr;
  logic [WAIT_W-1:0] r_wait;
  logic [TB-1:0]     r_bur;
  logic [PW-1:0]     p1;

  // Combinational helpers.
  logic [CW-1:0]     ac_ext;
  logic [NW-1:0]     act_n;
  logic [MAX_PROCESSES-1:0] act_mask;
  logic              undone_any;
  logic              cur_bad;
  logic              last;
  logic              accept;
  logic              out_free;
  logic [RW-1:0]     rdata, wdata;
  logic [IW-1:0]     waddr;
  logic              we;
  logic [TB-1:0]     e_arr_i, e_bur_i, bi;
  logic [WAIT_W-1:0] e_wait_i;
  logic [EW-1:0]     win_end;
  logic              in_win;
  logic              cand_e, cand_r;
  logic [WAIT_W-1:0] mul_a;
  logic [TB-1:0]     mul_b;
  logic [PW-1:0]     prod;
  logic              do_cmp;

  hfs_ram #(.WIDTH(RW), .DEPTH(MAX_PROCESSES)) u_proc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  // Active set and entry decode.
  always_comb begin
    ac_ext = CW'(active_count);
    act_n  = (ac_ext > CW'(MAX_PROCESSES)) ? NW'(MAX_PROCESSES) : NW'(ac_ext);
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      act_mask[i] = (i < int'(act_n));
    end
    undone_any = |(~done & act_mask);
    cur_bad    = ((NW + 1)'(cur) >= (NW + 1)'(act_n)) || done[cur];
    last       = ((NW + 1)'(idx) + (NW + 1)'(1)) >= (NW + 1)'(act_n);
    {e_arr_i, e_bur_i, e_wait_i} = rdata;
    bi         = (e_bur_i == '0) ? TB'(1) : e_bur_i;
    win_end    = EW'(e_arr_i) + EW'(e_bur_i) + EW'(e_wait_i);
    in_win     = (TW'(t_cur) >= TW'(e_arr_i)) && (EW'(t_cur) < win_end);
    cand_e     = (pk == PK_START) || !done[idx];
    cand_r     = policy && (pk != PK_START) && !done[idx] &&
                 (TW'(e_arr_i) <= TW'(t_cur));
    do_cmp     = cand_r && r_found;
  end

  // Shared multiplier for the exact ratio compare.
  always_comb begin
    if (state == S_SEL_CMP) begin
      mul_a = r_wait;
      mul_b = bi;
    end else begin
      mul_a = e_wait_i;
      mul_b = r_bur;
    end
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Handshake and RAM write control.
  always_comb begin
    req.ready = (state == S_IDLE);
    accept    = req.valid && req.ready;
    out_free  = !rsp.valid || rsp.ready;
    we        = 1'b0;
    waddr     = idx;
    wdata     = rdata;
    if (accept && req.data.opcode == OP_LOAD &&
        32'(req.data.entry_index) < MAX_PROCESSES) begin
      we    = 1'b1;
      waddr = IW'(req.data.entry_index);
      wdata = {TB'(req.data.arrival_time), TB'(req.data.burst_length), WAIT_W'(0)};
    end else if (state == S_TK_EV && in_win && idx != cur) begin
      we    = 1'b1;
      wdata = {e_arr_i, e_bur_i, (e_wait_i == MAX24) ? e_wait_i : e_wait_i + 1'b1};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.data.opcode)
            OP_START: state_next = (act_n == '0) ? S_OUT : S_SEL_RD;
            OP_TICK: begin
              if (!undone_any) begin
                state_next = S_OUT;
              end else if (cur_bad) begin
                state_next = S_SEL_RD;
              end else begin
                state_next = S_TK_RD;
              end
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_SEL_RD: state_next = S_SEL_EV;
      S_SEL_EV: begin
        if (do_cmp) begin
          state_next = S_SEL_CMP;
        end else begin
          state_next = last ? S_SEL_END : S_SEL_RD;
        end
      end
      S_SEL_CMP: state_next = last ? S_SEL_END : S_SEL_RD;
      S_SEL_END: state_next = (pk == PK_PRE) ? S_TK_RD : S_OUT;
      S_TK_RD:   state_next = S_TK_EV;
      S_TK_EV:   state_next = last ? S_TK_END : S_TK_RD;
      S_TK_END: begin
        state_next = (EW'(t_cur) + EW'(1) >= cur_end) ? S_SEL_RD : S_OUT;
      end
      S_OUT:     state_next = out_free ? S_IDLE : S_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      policy       <= 1'b1;
      active_count <= CFG_W'(1);
      done         <= '0;
      cur          <= '0;
      tick_counter <= '0;
      finished     <= '0;
      wait_sum     <= '0;
      run_sum      <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_POLICY) begin
          policy <= cfg_data[0];
        end else begin
          active_count <= cfg_data;
        end
      end
      // A new response word replaces one that is taken in the same cycle.
      if (state == S_OUT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && req.data.opcode == OP_LOAD &&
              32'(req.data.entry_index) < MAX_PROCESSES) begin
            done[IW'(req.data.entry_index)] <= 1'b0;
          end
        end
        S_SEL_END: begin
          if (policy && pk != PK_START && r_found) begin
            cur <= r_best;
          end else if (e_found) begin
            cur <= e_best;
          end
        end
        S_TK_EV: begin
          if (in_win) begin
            if (idx == cur) begin
              if (run_sum != MAX24) begin
                run_sum <= run_sum + 1'b1;
              end
            end else if (wait_sum != MAX32) begin
              wait_sum <= wait_sum + 1'b1;
            end
          end
        end
        S_TK_END: begin
          if (tick_counter != MAX24) begin
            tick_counter <= tick_counter + 1'b1;
          end
          if (EW'(t_cur) + EW'(1) >= cur_end) begin
            done[cur] <= 1'b1;
            if (finished != MAX7) begin
              finished <= finished + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the passes and the response word.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx     <= '0;
        t_cur   <= tick_counter;
        busy_f  <= 1'b0;
        fin_f   <= 1'b0;
        waiting <= '0;
        e_found <= 1'b0;
        r_found <= 1'b0;
        pk      <= (req.data.opcode == OP_START) ? PK_START : PK_PRE;
      end
      S_SEL_EV: begin
        if (cand_e && (!e_found || e_arr_i < e_arr)) begin
          e_found <= 1'b1;
          e_best  <= idx;
          e_arr   <= e_arr_i;
        end
        if (cand_r && !r_found) begin
          r_found <= 1'b1;
          r_best  <= idx;
          r_wait  <= e_wait_i;
          r_bur   <= bi;
        end
        p1 <= prod;
        if (!do_cmp && !last) begin
          idx <= idx + 1'b1;
        end
      end
      S_SEL_CMP: begin
        if (p1 > prod) begin
          r_best <= idx;
          r_wait <= e_wait_i;
          r_bur  <= bi;
        end
        if (!last) begin
          idx <= idx + 1'b1;
        end
      end
      S_SEL_END: begin
        idx <= '0;
      end
      S_TK_EV: begin
        if (idx == cur) begin
          cur_end <= win_end;
          if (in_win) begin
            busy_f <= 1'b1;
          end
        end else if (in_win) begin
          waiting <= waiting + 1'b1;
        end
        if (!last) begin
          idx <= idx + 1'b1;
        end
      end
      S_TK_END: begin
        idx     <= '0;
        pk      <= PK_POST;
        e_found <= 1'b0;
        r_found <= 1'b0;
        if (EW'(t_cur) + EW'(1) >= cur_end) begin
          fin_f <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          rsp.data.tick_number     <= t_cur;
          rsp.data.running_id      <= IDX_W'(cur);
          rsp.data.cpu_busy        <= busy_f;
          rsp.data.waiting_now     <= CNT_W'(waiting);
          rsp.data.finished_now    <= fin_f;
          rsp.data.completed_count <= finished;
          rsp.data.all_done        <= !undone_any;
          rsp.data.total_wait      <= wait_sum;
          rsp.data.total_run       <= run_sum;
        end
      end
      default: ;
    endcase
  end

endmodule
